@@ hdl/chm_pkg.sv @@
// Package with the commands, field widths and default sizes of the chained hash map.
package chm_pkg;

  localparam int KEY_W = 64;
  localparam int VALUE_W = 64;
  localparam int CMD_W = 3;
  localparam int COUNT_W = 10;
  localparam int DEFAULT_BUCKETS = 256;
  localparam int DEFAULT_NODES = 512;

  typedef enum logic [CMD_W-1:0] {
    CMD_LOOKUP = 3'd0,
    CMD_INSERT = 3'd1,
    CMD_UPDATE = 3'd2,
    CMD_REMOVE = 3'd3,
    CMD_CLEAR  = 3'd4
  } cmd_t;

endpackage

@@ hdl/chm_ram.sv @@
// Generic single-port RAM with a registered read.
module chm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    addr,
  input  logic [WIDTH-1:0] wdata,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

@@ hdl/chm_mod.sv @@
// Bucket index unit: reduces a key modulo the bucket count.
module chm_mod #(
  parameter int BUCKETS = chm_pkg::DEFAULT_BUCKETS,
  localparam int BW = (BUCKETS > 1) ? $clog2(BUCKETS) : 1
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  input  logic [chm_pkg::KEY_W-1:0] key,
  output logic                      done,
  output logic [BW-1:0]             bucket
);
  import chm_pkg::*;

  if ((BUCKETS & (BUCKETS - 1)) == 0) begin : g_pow2
    always_ff @(posedge clk) begin
      if (rst) begin
        done <= 1'b0;
      end else begin
        done <= start;
      end
      bucket <= BW'(key & KEY_W'(BUCKETS - 1));
    end
  end else begin : g_serial
    // Eight key bits are folded into the remainder per cycle, most significant first.
    localparam int STEPS = KEY_W / 8;
    logic [KEY_W-1:0] shift;
    logic [BW-1:0] rem;
    logic [BW-1:0] rem_next;
    logic [$clog2(STEPS)-1:0] cnt;
    logic active;

    always_comb begin
      logic [BW:0] t;
      rem_next = rem;
      for (int i = 0; i < 8; i++) begin
        t = {rem_next, shift[KEY_W-1-i]};
        if (t >= (BW+1)'(BUCKETS)) begin
          t = t - (BW+1)'(BUCKETS);
        end
        rem_next = t[BW-1:0];
      end
    end

    assign bucket = rem;

    always_ff @(posedge clk) begin
      if (rst) begin
        active <= 1'b0;
        done <= 1'b0;
      end else begin
        done <= 1'b0;
        if (start) begin
          active <= 1'b1;
          cnt <= '0;
          rem <= '0;
          shift <= key;
        end else if (active) begin
          rem <= rem_next;
          shift <= shift << 8;
          cnt <= cnt + 1'b1;
          if (cnt == ($clog2(STEPS))'(STEPS - 1)) begin
            active <= 1'b0;
            done <= 1'b1;
          end
        end
      end
    end
  end

endmodule

@@ hdl/chained_hash_map_64_unit.sv @@
// Top level of the chained hash map: command control, chain walk and node pool.
// A command is taken when start is high and busy is low; its single result shows on
// done, ok, read_value and element_count for one cycle and cannot be held off.
// A command passes the S_HASH, S_HEAD and S_HEADW states, one S_NODE per chain node
// visited, the S_REM2 state for remove and the S_ALLOC and S_PUSH states for a push. A
// bucket count not a power of two makes hashing serial; clear and unknown end in idle.
// All node and bucket memories are single ported, which sets one node per cycle.
module chained_hash_map_64_unit #(
  parameter int BUCKETS = chm_pkg::DEFAULT_BUCKETS,
  parameter int NODES = chm_pkg::DEFAULT_NODES
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  output logic                        busy,
  input  logic [chm_pkg::CMD_W-1:0]   cmd,
  input  logic [chm_pkg::KEY_W-1:0]   key,
  input  logic [chm_pkg::VALUE_W-1:0] write_value,
  output logic                        done,
  output logic                        ok,
  output logic [chm_pkg::VALUE_W-1:0] read_value,
  output logic [chm_pkg::COUNT_W-1:0] element_count
);
  import chm_pkg::*;

  localparam int BW = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
  localparam int NW = (NODES > 1) ? $clog2(NODES) : 1;
  localparam int CW = $clog2(NODES + 1);

  typedef enum logic [7:0] {
    S_IDLE  = 8'b0000_0001,
    S_HASH  = 8'b0000_0010,
    S_HEAD  = 8'b0000_0100,
    S_HEADW = 8'b0000_1000,
    S_NODE  = 8'b0001_0000,
    S_REM2  = 8'b0010_0000,
    S_ALLOC = 8'b0100_0000,
    S_PUSH  = 8'b1000_0000
  } state_t;

  state_t state;
  logic [CMD_W-1:0] cmd_q;
  logic [KEY_W-1:0] key_q;
  logic [VALUE_W-1:0] wval_q;
  logic [BW-1:0] bidx;
  logic [BUCKETS-1:0] bvalid;
  logic [NW-1:0] head_idx;
  logic head_valid;
  logic [NW-1:0] cur;
  logic [NW-1:0] prev;
  logic has_prev;
  logic [NW-1:0] rec_top;
  logic rec_valid;
  logic [CW-1:0] fresh;
  logic [CW-1:0] count;
  logic [NW-1:0] n_alloc;
  logic from_rec;

  logic hash_start;
  logic hash_done;
  logic [BW-1:0] hash_bucket;

  logic bk_we;
  logic [NW-1:0] bk_wdata;
  logic [NW-1:0] bk_rdata;
  logic nk_we;
  logic [NW-1:0] nk_addr;
  logic [KEY_W-1:0] nk_rdata;
  logic nv_we;
  logic [NW-1:0] nv_addr;
  logic [VALUE_W-1:0] nv_wdata;
  logic [VALUE_W-1:0] nv_rdata;
  logic nl_we;
  logic [NW-1:0] nl_addr;
  logic [NW:0] nl_wdata;
  logic [NW:0] nl_rdata;
  logic hit;
  logic known;

  assign busy = (state != S_IDLE);
  assign element_count = COUNT_W'(count);
  assign hit = (nk_rdata == key_q);
  assign known = (cmd == CMD_LOOKUP) || (cmd == CMD_INSERT) || (cmd == CMD_UPDATE) ||
                 (cmd == CMD_REMOVE);
  assign hash_start = start && !busy && known;

  chm_mod #(.BUCKETS(BUCKETS)) u_mod (
    .clk    (clk),
    .rst    (rst),
    .start  (hash_start),
    .key    (key),
    .done   (hash_done),
    .bucket (hash_bucket)
  );

  chm_ram #(.WIDTH(NW), .DEPTH(BUCKETS)) u_bucket_ram (
    .clk   (clk),
    .we    (bk_we),
    .addr  (bidx),
    .wdata (bk_wdata),
    .rdata (bk_rdata)
  );

  chm_ram #(.WIDTH(KEY_W), .DEPTH(NODES)) u_key_ram (
    .clk   (clk),
    .we    (nk_we),
    .addr  (nk_addr),
    .wdata (key_q),
    .rdata (nk_rdata)
  );

  chm_ram #(.WIDTH(VALUE_W), .DEPTH(NODES)) u_value_ram (
    .clk   (clk),
    .we    (nv_we),
    .addr  (nv_addr),
    .wdata (nv_wdata),
    .rdata (nv_rdata)
  );

  chm_ram #(.WIDTH(NW + 1), .DEPTH(NODES)) u_link_ram (
    .clk   (clk),
    .we    (nl_we),
    .addr  (nl_addr),
    .wdata (nl_wdata),
    .rdata (nl_rdata)
  );

  always_comb begin
    bk_we = 1'b0;
    bk_wdata = nl_rdata[NW-1:0];
    nk_we = 1'b0;
    nk_addr = nl_rdata[NW-1:0];
    nv_we = 1'b0;
    nv_addr = nl_rdata[NW-1:0];
    nv_wdata = wval_q;
    nl_we = 1'b0;
    nl_addr = nl_rdata[NW-1:0];
    nl_wdata = nl_rdata;
    unique case (state)
      S_HEADW: begin
        nk_addr = bk_rdata;
        nv_addr = bk_rdata;
        nl_addr = bk_rdata;
      end
      S_NODE: begin
        if (hit && (cmd_q == CMD_UPDATE)) begin
          nv_we = 1'b1;
          nv_addr = cur;
        end
        if (hit && (cmd_q == CMD_REMOVE)) begin
          if (has_prev) begin
            nl_we = 1'b1;
            nl_addr = prev;
          end else begin
            bk_we = 1'b1;
          end
        end
      end
      S_REM2: begin
        nl_we = 1'b1;
        nl_addr = cur;
        nl_wdata = {rec_valid, rec_top};
      end
      S_ALLOC: begin
        nl_addr = rec_top;
      end
      S_PUSH: begin
        bk_we = 1'b1;
        bk_wdata = n_alloc;
        nk_we = 1'b1;
        nk_addr = n_alloc;
        nv_we = 1'b1;
        nv_addr = n_alloc;
        nl_we = 1'b1;
        nl_addr = n_alloc;
        nl_wdata = {head_valid, head_idx};
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      done <= 1'b0;
      bvalid <= '0;
      rec_valid <= 1'b0;
      fresh <= '0;
      count <= '0;
    end else begin
      done <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (start) begin
            cmd_q <= cmd;
            key_q <= key;
            wval_q <= write_value;
            if (hash_start) begin
              state <= S_HASH;
            end else begin
              done <= 1'b1;
              read_value <= '0;
              ok <= (cmd == CMD_CLEAR);
              if (cmd == CMD_CLEAR) begin
                bvalid <= '0;
                rec_valid <= 1'b0;
                fresh <= '0;
                count <= '0;
              end
            end
          end
        end
        S_HASH: begin
          if (hash_done) begin
            bidx <= hash_bucket;
            state <= S_HEAD;
          end
        end
        S_HEAD: begin
          state <= S_HEADW;
        end
        S_HEADW: begin
          head_idx <= bk_rdata;
          head_valid <= bvalid[bidx];
          cur <= bk_rdata;
          has_prev <= 1'b0;
          if (cmd_q == CMD_INSERT) begin
            state <= S_ALLOC;
          end else if (bvalid[bidx]) begin
            state <= S_NODE;
          end else if (cmd_q == CMD_UPDATE) begin
            state <= S_ALLOC;
          end else begin
            done <= 1'b1;
            ok <= 1'b0;
            read_value <= '0;
            state <= S_IDLE;
          end
        end
        S_NODE: begin
          if (hit) begin
            if (cmd_q == CMD_REMOVE) begin
              if (!has_prev) begin
                bvalid[bidx] <= nl_rdata[NW];
              end
              state <= S_REM2;
            end else begin
              done <= 1'b1;
              ok <= 1'b1;
              read_value <= (cmd_q == CMD_LOOKUP) ? nv_rdata : '0;
              state <= S_IDLE;
            end
          end else if (nl_rdata[NW]) begin
            prev <= cur;
            has_prev <= 1'b1;
            cur <= nl_rdata[NW-1:0];
          end else if (cmd_q == CMD_UPDATE) begin
            state <= S_ALLOC;
          end else begin
            done <= 1'b1;
            ok <= 1'b0;
            read_value <= '0;
            state <= S_IDLE;
          end
        end
        S_REM2: begin
          rec_top <= cur;
          rec_valid <= 1'b1;
          count <= count - 1'b1;
          done <= 1'b1;
          ok <= 1'b1;
          read_value <= '0;
          state <= S_IDLE;
        end
        S_ALLOC: begin
          if (count >= CW'(NODES)) begin
            done <= 1'b1;
            ok <= 1'b0;
            read_value <= '0;
            state <= S_IDLE;
          end else begin
            n_alloc <= rec_valid ? rec_top : fresh[NW-1:0];
            from_rec <= rec_valid;
            state <= S_PUSH;
          end
        end
        S_PUSH: begin
          if (from_rec) begin
            rec_valid <= nl_rdata[NW];
            rec_top <= nl_rdata[NW-1:0];
          end else begin
            fresh <= fresh + 1'b1;
          end
          bvalid[bidx] <= 1'b1;
          count <= count + 1'b1;
          done <= 1'b1;
          ok <= 1'b1;
          read_value <= '0;
          state <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

@@ bench/chm_checker.sv @@
// Checker that predicts chained hash map results and compares them with the block.
module chm_checker (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic                          busy,
  input  logic [chm_pkg::CMD_W-1:0]     cmd,
  input  logic [chm_pkg::KEY_W-1:0]     key,
  input  logic [chm_pkg::VALUE_W-1:0]   write_value,
  input  logic                          done,
  input  logic                          ok,
  input  logic [chm_pkg::VALUE_W-1:0]   read_value,
  input  logic [chm_pkg::COUNT_W-1:0]   element_count,
  output int                            fail_count,
  output int                            pending,
  output int                            hits
);
  import chm_pkg::*;

  localparam int NB = DEFAULT_BUCKETS;
  localparam int NN = DEFAULT_NODES;

  typedef struct packed {
    logic               ok;
    logic [VALUE_W-1:0] value;
    logic [COUNT_W-1:0] count;
  } map_result_t;

  map_result_t expected_results[$];

  logic [9:0]         head_node [NB];
  logic               head_used [NB];
  logic [KEY_W-1:0]   pool_key [NN];
  logic [VALUE_W-1:0] pool_value [NN];
  logic [9:0]         pool_next [NN];
  logic               next_used [NN];
  int                 free_node;
  int                 live_count;

  function automatic void clear_map();
    for (int i = 0; i < NB; i++) begin
      head_node[i] = '0;
      head_used[i] = 1'b0;
    end
    for (int i = 0; i < NN; i++) begin
      pool_key[i] = '0;
      pool_value[i] = '0;
      pool_next[i] = 10'(i + 1);
      next_used[i] = (i + 1) < NN;
    end
    free_node = 0;
    live_count = 0;
  endfunction

  function automatic bit find_key(input logic [KEY_W-1:0] k, output int node,
                                  output bit has_prev, output int prev);
    int b;
    bit live;
    int cur;
    b = int'(k % NB);
    live = head_used[b];
    cur = head_node[b];
    has_prev = 0;
    prev = 0;
    node = 0;
    for (int steps = 0; live && cur < NN && steps < NN; steps++) begin
      if (pool_key[cur] == k) begin
        node = cur;
        return 1;
      end
      has_prev = 1;
      prev = cur;
      live = next_used[cur];
      cur = pool_next[cur];
    end
    return 0;
  endfunction

  function automatic bit push_node(input logic [KEY_W-1:0] k, input logic [VALUE_W-1:0] v);
    int n;
    int b;
    if (live_count >= NN || free_node >= NN) return 0;
    n = free_node;
    free_node = pool_next[n];
    b = int'(k % NB);
    pool_next[n] = head_node[b];
    next_used[n] = head_used[b];
    head_node[b] = 10'(n);
    head_used[b] = 1'b1;
    pool_key[n] = k;
    pool_value[n] = v;
    live_count++;
    return 1;
  endfunction

  function automatic map_result_t apply_command(input logic [CMD_W-1:0] c,
                                                input logic [KEY_W-1:0] k,
                                                input logic [VALUE_W-1:0] v);
    map_result_t r;
    int n;
    int p;
    int b;
    bit hp;
    r = '0;
    case (c)
      CMD_LOOKUP: if (find_key(k, n, hp, p)) begin
        r.ok = 1'b1;
        r.value = pool_value[n];
      end
      CMD_INSERT: r.ok = push_node(k, v);
      CMD_UPDATE: if (find_key(k, n, hp, p)) begin
        pool_value[n] = v;
        r.ok = 1'b1;
      end else begin
        r.ok = push_node(k, v);
      end
      CMD_REMOVE: if (find_key(k, n, hp, p)) begin
        if (hp) begin
          pool_next[p] = pool_next[n];
          next_used[p] = next_used[n];
        end else begin
          b = int'(k % NB);
          head_node[b] = pool_next[n];
          head_used[b] = next_used[n];
        end
        pool_next[n] = 10'(free_node);
        next_used[n] = 1'b1;
        free_node = n;
        if (live_count > 0) live_count--;
        r.ok = 1'b1;
      end
      CMD_CLEAR: begin
        clear_map();
        r.ok = 1'b1;
      end
      default: ;
    endcase
    r.count = COUNT_W'(live_count);
    return r;
  endfunction

  initial begin
    clear_map();
    fail_count = 0;
    pending = 0;
    hits = 0;
  end

  always @(posedge clk) begin
    map_result_t got;
    map_result_t want;
    if (!rst) begin
      if (start && !busy) expected_results.push_back(apply_command(cmd, key, write_value));
      if (done) begin
        got = '{ok, read_value, element_count};
        if (expected_results.size() == 0) begin
          $display("%0t: result with none expected: ok %0b value %h count %0d",
                   $time, ok, read_value, element_count);
          fail_count++;
        end else begin
          want = expected_results.pop_front();
          if (want.ok) hits++;
          if (got.ok !== want.ok) begin
            $display("%0t: ok expected %0b actual %0b", $time, want.ok, got.ok);
            fail_count++;
          end
          if (got.value !== want.value) begin
            $display("%0t: read_value expected %h actual %h", $time, want.value, got.value);
            fail_count++;
          end
          if (got.count !== want.count) begin
            $display("%0t: element_count expected %0d actual %0d",
                     $time, want.count, got.count);
            fail_count++;
          end
        end
      end
      pending <= expected_results.size();
    end
  end
endmodule

@@ bench/tb_chained_hash_map_64_unit.sv @@
// Testbench top for the chained hash map: command stimulus, checker and verdict.
module tb_chained_hash_map_64_unit;
  import chm_pkg::*;

  logic               clk;
  logic               rst;
  logic               start;
  logic               busy;
  logic [CMD_W-1:0]   cmd;
  logic [KEY_W-1:0]   key;
  logic [VALUE_W-1:0] write_value;
  logic               done;
  logic               ok;
  logic [VALUE_W-1:0] read_value;
  logic [COUNT_W-1:0] element_count;
  int                 fail_count;
  int                 pending;
  int                 hits;
  int                 sent;
  int                 idle_cycles;
  logic [KEY_W-1:0]   key_pool [16];

  chained_hash_map_64_unit u_dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .cmd(cmd), .key(key),
    .write_value(write_value), .done(done), .ok(ok), .read_value(read_value),
    .element_count(element_count)
  );

  chm_checker u_checker (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .cmd(cmd), .key(key),
    .write_value(write_value), .done(done), .ok(ok), .read_value(read_value),
    .element_count(element_count), .fail_count(fail_count), .pending(pending),
    .hits(hits)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin
    if (rst || (start && !busy) || done) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles > 20000) begin
        $display("%0t: no transfer for too long", $time);
        $display("tb_chained_hash_map_64_unit: done, errors");
        $finish;
      end
    end
  end

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  task automatic send(input logic [CMD_W-1:0] c, input logic [KEY_W-1:0] k,
                      input logic [VALUE_W-1:0] v);
    start <= 1'b1;
    cmd <= c;
    key <= k;
    write_value <= v;
    do @(posedge clk); while (busy);
    sent++;
  endtask

  task automatic pause(input int n);
    start <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  task automatic drain();
    start <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  initial begin
    logic [KEY_W-1:0] k;
    int pick;
    int burst;
    rst = 1'b1;
    start = 1'b0;
    cmd = '0;
    key = '0;
    write_value = '0;
    sent = 0;
    idle_cycles = 0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    while (busy) @(posedge clk);

    send(CMD_LOOKUP, 64'd5, '0);
    send(CMD_REMOVE, 64'd5, '0);
    send(CMD_INSERT, '1, '1);
    send(CMD_INSERT, '0, '0);
    send(CMD_INSERT, 64'd256, 64'hA5A5);
    send(CMD_INSERT, 64'd256, 64'h5A5A);
    send(CMD_LOOKUP, 64'd256, '0);
    send(CMD_LOOKUP, 64'd0, '0);
    send(CMD_LOOKUP, '1, '0);
    send(CMD_UPDATE, 64'd256, 64'h1234);
    send(CMD_UPDATE, 64'd512, 64'h77);
    send(CMD_REMOVE, 64'd256, '0);
    send(CMD_LOOKUP, 64'd256, '0);
    send(CMD_REMOVE, 64'd0, '0);
    send(3'd5, 64'd1, 64'd1);
    send(3'd6, '1, '1);
    send(3'd7, 64'd2, 64'd2);
    send(CMD_CLEAR, '0, '0);
    send(CMD_LOOKUP, '1, '0);
    for (int i = 0; i < 513; i++) send(CMD_INSERT, rand64(), rand64());
    send(CMD_UPDATE, 64'd3, 64'd9);
    send(CMD_CLEAR, '0, '0);
    drain();

    for (int i = 0; i < 16; i++) key_pool[i] = rand64();
    while (sent < 1500) begin
      burst = $urandom_range(1, 24);
      for (int j = 0; j < burst; j++) begin
        if ($urandom_range(0, 3) == 0) k = rand64();
        else k = key_pool[$urandom_range(0, 15)] + KEY_W'($urandom_range(0, 3) * 256);
        pick = $urandom_range(0, 99);
        if (pick < 30) send(CMD_LOOKUP, k, rand64());
        else if (pick < 52) send(CMD_INSERT, k, rand64());
        else if (pick < 72) send(CMD_UPDATE, k, rand64());
        else if (pick < 95) send(CMD_REMOVE, k, rand64());
        else if (pick < 97) send(CMD_CLEAR, k, rand64());
        else send(3'($urandom_range(5, 7)), k, rand64());
      end
      if ($urandom_range(0, 9) == 0) drain();
      else if ($urandom_range(0, 2) != 0) pause($urandom_range(1, 12));
    end
    drain();
    repeat (50) @(posedge clk);

    $display("Sent %0d commands (directed edge cases, pool overflow, random mix);", sent);
    $display("%0d results reported ok.", hits);
    if (fail_count == 0) begin
      $display("tb_chained_hash_map_64_unit: done, clean");
    end else begin
      $display("tb_chained_hash_map_64_unit: done, errors");
    end
    $finish;
  end
endmodule

@@ filelist.f @@
hdl/chm_pkg.sv
hdl/chm_ram.sv
hdl/chm_mod.sv
hdl/chained_hash_map_64_unit.sv
bench/chm_checker.sv
bench/tb_chained_hash_map_64_unit.sv
